FILE: rtl/radial_alpha_brush_mask_macros.svh
// ----------------------------------------------------------------------------
// Radial alpha brush mask - assertion macros
// Concurrent check macros shared by the RTL. They expand to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RADIAL_ALPHA_BRUSH_MASK_MACROS_SVH
`define RADIAL_ALPHA_BRUSH_MASK_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define RABM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rabm check failed");
// next-cycle implication
`define RABM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rabm check failed");
`else
`define RABM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RABM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/rabm_pkg.sv
// ----------------------------------------------------------------------------
// Radial alpha brush mask - package
// Widths, register indexes and the word types passed between the pipeline
// sections.
// ----------------------------------------------------------------------------
package rabm_pkg;

    // brush geometry
    localparam int MAX_DIM = 1024;
    localparam int DIM_W   = 11;
    localparam int COORD_W = 10;
    localparam int HALF_W  = 10;    // centre and radius, up to MAX_DIM/2
    localparam int DELTA_W = 11;    // signed offset from the centre
    localparam int SQ_W    = 20;    // square of one offset
    localparam int D2_W    = 21;    // squared distance

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd64;

    // colour
    localparam int CH_W = 8;
    localparam logic [CH_W-1:0] ALPHA_MAX = 8'd255;

    // distance scaling: isqrt(255^2 * d2)
    localparam int SCALE_W = 16;
    localparam logic [SCALE_W-1:0] SCALE_SQ = 16'd65025;
    localparam int PROD_W     = D2_W + SCALE_W;
    localparam int SQ_PAIRS   = 20;
    localparam int RADICAND_W = 2 * SQ_PAIRS;
    localparam int ROOT_W     = SQ_PAIRS;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SQ_STAGES  = SQ_PAIRS / 2;     // two root bits per stage

    // root / radius divider
    localparam int RAD255_W   = 17;
    localparam int DIV_REM_W  = 17;
    localparam int Q_W        = 8;
    localparam int DIV_STAGES = Q_W / 2;          // two quotient bits per stage

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRUSH_HEIGHT = 2'd1;

    typedef struct packed {
        logic [HALF_W-1:0]   cx;
        logic [HALF_W-1:0]   cy;
        logic [HALF_W-1:0]   rad;
        logic [RAD255_W-1:0] rad255;
    } rabm_cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rabm_color_t;

    typedef struct packed {
        logic [RADICAND_W-1:0] radicand;
        rabm_color_t           color;
    } rabm_dist_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        rabm_color_t       color;
    } rabm_root_t;

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rabm_pix_t;

endpackage

FILE: rtl/rabm_dist.sv
// ----------------------------------------------------------------------------
// Radial alpha brush mask - distance section
// Four stages: offsets from the centre, squares, sum, scale by 255^2.
// ----------------------------------------------------------------------------
module rabm_dist (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rabm_pkg::rabm_cfg_t        cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rabm_pkg::COORD_W-1:0] col,
    input  logic [rabm_pkg::COORD_W-1:0] row,
    input  rabm_pkg::rabm_color_t      in_color,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rabm_pkg::rabm_dist_t       out_data
);
    import rabm_pkg::*;

    localparam int STAGES = 4;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv;

    logic signed [DELTA_W-1:0]   dx_next, dy_next, dx_reg, dy_reg;
    logic signed [2*DELTA_W-1:0] sqx_full, sqy_full;
    logic [SQ_W-1:0]             sqx_reg, sqy_reg;
    logic [D2_W-1:0]             d2_next, d2_reg;
    logic [PROD_W-1:0]           prod_next;
    logic [RADICAND_W-1:0]       radicand_reg;
    rabm_color_t                 color_a_reg, color_b_reg, color_c_reg, color_d_reg;

    // stage advance chain: a stage loads when empty or when its word moves on
    assign adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
    for (genvar i = 0; i < STAGES - 1; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end
    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // offsets, squares, sum, constant scale
    assign dx_next   = $signed({1'b0, col}) - $signed({1'b0, cfg.cx});
    assign dy_next   = $signed({1'b0, row}) - $signed({1'b0, cfg.cy});
    assign sqx_full  = dx_reg * dx_reg;
    assign sqy_full  = dy_reg * dy_reg;
    assign d2_next   = D2_W'(sqx_reg) + D2_W'(sqy_reg);
    assign prod_next = PROD_W'(d2_reg) * PROD_W'(SCALE_SQ);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            color_a_reg <= in_color;
        end
        if (adv[1]) begin
            sqx_reg     <= sqx_full[SQ_W-1:0];
            sqy_reg     <= sqy_full[SQ_W-1:0];
            color_b_reg <= color_a_reg;
        end
        if (adv[2]) begin
            d2_reg      <= d2_next;
            color_c_reg <= color_b_reg;
        end
        if (adv[3]) begin
            radicand_reg <= RADICAND_W'(prod_next);
            color_d_reg  <= color_c_reg;
        end
    end

    assign out_valid         = vld_reg[STAGES-1];
    assign out_data.radicand = radicand_reg;
    assign out_data.color    = color_d_reg;

endmodule

FILE: rtl/rabm_isqrt.sv
// ----------------------------------------------------------------------------
// Radial alpha brush mask - square root section
// Digit-by-digit integer square root, two root bits per pipeline stage.
// ----------------------------------------------------------------------------
`include "radial_alpha_brush_mask_macros.svh"

module rabm_isqrt (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rabm_pkg::rabm_dist_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rabm_pkg::rabm_root_t out_data
);
    import rabm_pkg::*;

    localparam int LAST = SQ_STAGES - 1;

    typedef struct packed {
        logic [RADICAND_W-1:0] radicand;
        logic [ROOT_W-1:0]     root;
        logic [REM_W-1:0]      rem;
        rabm_color_t           color;
    } sq_stage_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } sq_step_t;

    // one root bit: bring down a bit pair, try 4*root+1
    function automatic sq_step_t sq_step(input logic [ROOT_W-1:0] root,
                                         input logic [REM_W-1:0]  rem,
                                         input logic [1:0]        pair);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        sq_step_t         res;
        rem_sh = {rem, pair};
        trial  = (REM_W + 2)'({root, 2'b01});
        if (rem_sh >= trial) begin
            res.rem  = REM_W'(rem_sh - trial);
            res.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = REM_W'(rem_sh);
            res.root = {root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    logic [SQ_STAGES-1:0] vld_reg;
    logic [SQ_STAGES-1:0] adv;
    sq_stage_t            stage_in   [SQ_STAGES];
    sq_stage_t            stage_next [SQ_STAGES];
    sq_stage_t            stage_reg  [SQ_STAGES];
    logic [REM_W-1:0]     rem_bound;

    assign adv[LAST] = !vld_reg[LAST] || out_ready;
    for (genvar i = 0; i < LAST; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end
    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < SQ_STAGES; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // root stages: the top bit pairs go first
    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
        sq_step_t step_a;
        sq_step_t step_b;

        if (s == 0) begin : g_first
            always_comb begin
                stage_in[s].radicand = in_data.radicand;
                stage_in[s].root     = '0;
                stage_in[s].rem      = '0;
                stage_in[s].color    = in_data.color;
            end
        end else begin : g_rest
            assign stage_in[s] = stage_reg[s-1];
        end

        always_comb begin
            step_a = sq_step(stage_in[s].root, stage_in[s].rem,
                             stage_in[s].radicand[RADICAND_W-1-4*s -: 2]);
            step_b = sq_step(step_a.root, step_a.rem,
                             stage_in[s].radicand[RADICAND_W-3-4*s -: 2]);
            stage_next[s]      = stage_in[s];
            stage_next[s].root = step_b.root;
            stage_next[s].rem  = step_b.rem;
        end

        always_ff @(posedge aclk) begin
            if (adv[s]) begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign out_valid      = vld_reg[LAST];
    assign out_data.root  = stage_reg[LAST].root;
    assign out_data.color = stage_reg[LAST].color;

    // remainder never exceeds twice the root
    assign rem_bound = {stage_reg[LAST].root, 1'b0};

    `RABM_ASSERT_NOW(a_rem_bound, aclk, aresetn, vld_reg[LAST], stage_reg[LAST].rem <= rem_bound)

endmodule

FILE: rtl/rabm_scale.sv
// ----------------------------------------------------------------------------
// Radial alpha brush mask - alpha and premultiply section
// Saturation check, root/radius divider (two quotient bits per stage),
// alpha, channel products and the divide by 255.
// ----------------------------------------------------------------------------
`include "radial_alpha_brush_mask_macros.svh"

module rabm_scale (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rabm_pkg::rabm_cfg_t  cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rabm_pkg::rabm_root_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rabm_pkg::rabm_pix_t  out_data
);
    import rabm_pkg::*;

    localparam int ALPHA_STG = DIV_STAGES + 1;
    localparam int MUL_STG   = ALPHA_STG + 1;
    localparam int OUT_STG   = MUL_STG + 1;
    localparam int STAGES    = OUT_STG + 1;
    localparam int PROD_CH_W = 2 * CH_W;

    typedef struct packed {
        logic                 over;
        logic [DIV_REM_W-1:0] rem;
        logic [Q_W-1:0]       quo;
        rabm_color_t          color;
    } dv_stage_t;

    typedef struct packed {
        logic [DIV_REM_W-1:0] rem;
        logic [Q_W-1:0]       quo;
    } dv_step_t;

    // one restoring step against the shifted divisor
    function automatic dv_step_t dv_step(input logic [DIV_REM_W-1:0] rem,
                                         input logic [Q_W-1:0]       quo,
                                         input logic [DIV_REM_W-1:0] dsor);
        dv_step_t res;
        if (rem >= dsor) begin
            res.rem = rem - dsor;
            res.quo = {quo[Q_W-2:0], 1'b1};
        end else begin
            res.rem = rem;
            res.quo = {quo[Q_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // x/255 for x <= 255*255: (x + 1 + x/256) / 256
    function automatic logic [CH_W-1:0] div255(input logic [PROD_CH_W-1:0] x);
        logic [PROD_CH_W:0] sum;
        sum = (PROD_CH_W + 1)'(x) + (PROD_CH_W + 1)'(1)
            + (PROD_CH_W + 1)'(x[PROD_CH_W-1:CH_W]);
        return sum[PROD_CH_W-1:CH_W];
    endfunction

    logic [STAGES-1:0]    vld_reg;
    logic [STAGES-1:0]    adv;
    dv_stage_t            dv_next [DIV_STAGES+1];
    dv_stage_t            dv_reg  [DIV_STAGES+1];
    logic [CH_W-1:0]      alpha_next, alpha_reg, alpha_m_reg;
    rabm_color_t          color_a_reg;
    logic [PROD_CH_W-1:0] pb_reg, pg_reg, pr_reg;
    rabm_pix_t            pix_next, pix_reg;

    assign adv[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
    for (genvar i = 0; i < STAGES - 1; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end
    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // saturation: quotient of 255 or more, or zero radius, gives alpha 0
    always_comb begin
        dv_next[0].over  = (cfg.rad == '0) || (in_data.root >= ROOT_W'(cfg.rad255));
        dv_next[0].rem   = in_data.root[DIV_REM_W-1:0];
        dv_next[0].quo   = '0;
        dv_next[0].color = in_data.color;
    end

    // divider stages, top quotient bits first
    for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
        localparam int KA = Q_W - 1 - 2 * d;
        localparam int KB = KA - 1;
        dv_step_t step_a;
        dv_step_t step_b;

        always_comb begin
            step_a = dv_step(dv_reg[d].rem, dv_reg[d].quo,
                             DIV_REM_W'(cfg.rad) << KA);
            step_b = dv_step(step_a.rem, step_a.quo,
                             DIV_REM_W'(cfg.rad) << KB);
            dv_next[d+1]     = dv_reg[d];
            dv_next[d+1].rem = step_b.rem;
            dv_next[d+1].quo = step_b.quo;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i <= DIV_STAGES; i++) begin
            if (adv[i]) begin
                dv_reg[i] <= dv_next[i];
            end
        end
    end

    // alpha, products, divide by 255
    assign alpha_next = dv_reg[DIV_STAGES].over ? '0 : ALPHA_MAX - dv_reg[DIV_STAGES].quo;

    always_comb begin
        pix_next.blue  = div255(pb_reg);
        pix_next.green = div255(pg_reg);
        pix_next.red   = div255(pr_reg);
        pix_next.alpha = alpha_m_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[ALPHA_STG]) begin
            alpha_reg   <= alpha_next;
            color_a_reg <= dv_reg[DIV_STAGES].color;
        end
        if (adv[MUL_STG]) begin
            pb_reg      <= PROD_CH_W'(color_a_reg.blue) * PROD_CH_W'(alpha_reg);
            pg_reg      <= PROD_CH_W'(color_a_reg.green) * PROD_CH_W'(alpha_reg);
            pr_reg      <= PROD_CH_W'(color_a_reg.red) * PROD_CH_W'(alpha_reg);
            alpha_m_reg <= alpha_reg;
        end
        if (adv[OUT_STG]) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = vld_reg[OUT_STG];
    assign out_data  = pix_reg;

    `RABM_ASSERT_NEXT(a_alpha_hold, aclk, aresetn, vld_reg[ALPHA_STG] && !adv[ALPHA_STG], vld_reg[ALPHA_STG] && $stable(alpha_reg))
    `RABM_ASSERT_NOW(a_zero_alpha, aclk, aresetn, vld_reg[MUL_STG] && (alpha_m_reg == '0), (pb_reg == '0) && (pg_reg == '0) && (pr_reg == '0))
    `RABM_ASSERT_NOW(a_ch_le_alpha, aclk, aresetn, vld_reg[OUT_STG], (pix_reg.blue <= pix_reg.alpha) && (pix_reg.green <= pix_reg.alpha) && (pix_reg.red <= pix_reg.alpha))

endmodule

FILE: rtl/radial_alpha_brush_mask.sv
// ----------------------------------------------------------------------------
// Radial alpha brush mask - top level
// Alpha from the distance to the brush centre, premultiplied into the pixel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one premultiplied pixel with its
// alpha per clock while m_tready is high (4 distance stages, 10
// square root stages at two root bits each, 8 divide/alpha/premultiply
// stages). Every stage holds a word with its own valid bit, so the pipe
// keeps taking pixels while a result waits, until it fills. Brush width and
// height are written through the cfg port (values above 1024 saturate) and
// must only change while no pixel is in flight.
// ----------------------------------------------------------------------------
module radial_alpha_brush_mask (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_wr_en,
    input  logic [rabm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rabm_pkg::DIM_W-1:0]   cfg_wdata,
    // pixel in
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [47:0]                  s_tdata,   // col, row, in_blue, in_green, in_red
    // pixel out
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata    // out_blue, out_green, out_red, out_alpha
);
    import rabm_pkg::*;

    logic [DIM_W-1:0]     width_reg, height_reg, dim_next, big;
    logic [HALF_W+CH_W-1:0] rad_x256;
    rabm_cfg_t            cfg;
    logic [COORD_W-1:0]   col, row;
    rabm_color_t          in_color;
    logic                 dist_valid, dist_ready, root_valid, root_ready;
    rabm_dist_t           dist_data;
    rabm_root_t           root_data;
    rabm_pix_t            pix;

    // configuration registers, saturated at write
    assign dim_next = (cfg_wdata > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BRUSH_WIDTH:  width_reg  <= dim_next;
                REG_BRUSH_HEIGHT: height_reg <= dim_next;
                default: ;
            endcase
        end
    end

    // centre, radius and 255*radius
    assign big      = (width_reg > height_reg) ? width_reg : height_reg;
    assign rad_x256 = {big[DIM_W-1:1], {CH_W{1'b0}}};

    always_comb begin
        cfg.cx     = width_reg[DIM_W-1:1];
        cfg.cy     = height_reg[DIM_W-1:1];
        cfg.rad    = big[DIM_W-1:1];
        cfg.rad255 = RAD255_W'(rad_x256 - (HALF_W + CH_W)'(big[DIM_W-1:1]));
    end

    // unpack the input word
    assign col            = s_tdata[9:0];
    assign row            = s_tdata[19:10];
    assign in_color.blue  = s_tdata[27:20];
    assign in_color.green = s_tdata[35:28];
    assign in_color.red   = s_tdata[43:36];

    rabm_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .col       (col),
        .row       (row),
        .in_color  (in_color),
        .out_valid (dist_valid),
        .out_ready (dist_ready),
        .out_data  (dist_data)
    );

    rabm_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dist_valid),
        .in_ready  (dist_ready),
        .in_data   (dist_data),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .out_data  (root_data)
    );

    rabm_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (root_valid),
        .in_ready  (root_ready),
        .in_data   (root_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (pix)
    );

    // pack the output word
    assign m_tdata = {pix.alpha, pix.red, pix.green, pix.blue};

endmodule

FILE: sim/brush_mask_checker.sv
// ----------------------------------------------------------------------------
// Brush mask checker
// Watches the config port and both pixel streams of the radial alpha brush
// mask, keeps its own brush size, predicts each premultiplied pixel and
// compares it field by field with the block's output in order.
// ----------------------------------------------------------------------------
module brush_mask_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rabm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rabm_pkg::DIM_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [47:0]                    s_tdata,   // col, row, in_blue, in_green, in_red
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [31:0]                    m_tdata,   // out_blue, out_green, out_red, out_alpha
    output int                             mismatches,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rabm_pkg::*;

    logic [DIM_W-1:0] brush_w = DIM_RESET;
    logic [DIM_W-1:0] brush_h = DIM_RESET;
    rabm_pix_t        premul_q[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // writes above the largest brush clamp to it
    function automatic logic [DIM_W-1:0] clip_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? DIM_W'(MAX_DIM) : v;
    endfunction

    // radial falloff alpha and premultiplied channels for one pixel
    function automatic rabm_pix_t shade_pixel(input logic [COORD_W-1:0] col,
                                              input logic [COORD_W-1:0] row,
                                              input rabm_color_t        c);
        int                dx, dy;
        longint unsigned   scaled, root, trial;
        int unsigned       rad, dis, a;
        rabm_pix_t         p;
        dx = int'(col) - int'(brush_w >> 1);
        dy = int'(row) - int'(brush_h >> 1);
        scaled = 64'd65025 * longint'(dx * dx + dy * dy);
        // integer square root, one bit at a time from the top
        root = 0;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= scaled)
                root = trial;
        end
        rad = ((brush_w > brush_h) ? brush_w : brush_h) >> 1;
        if (rad == 0) begin
            a = 0;      // degenerate brush: fully transparent
        end else begin
            dis = int'(root / rad);
            a = (dis >= 255) ? 0 : 255 - dis;
        end
        p.alpha = CH_W'(a);
        p.blue  = CH_W'((int'(c.blue)  * a) / 255);
        p.green = CH_W'((int'(c.green) * a) / 255);
        p.red   = CH_W'((int'(c.red)   * a) / 255);
        return p;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // track config, queue predictions, compare results
    always @(posedge aclk) begin : track
        rabm_pix_t   want;
        rabm_pix_t   got;
        rabm_color_t c;
        if (!aresetn) begin
            brush_w = DIM_RESET;
            brush_h = DIM_RESET;
            premul_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_BRUSH_WIDTH:  brush_w = clip_dim(cfg_wdata);
                    REG_BRUSH_HEIGHT: brush_h = clip_dim(cfg_wdata);
                    default: ;      // unmapped index, no effect
                endcase
            end
            if (s_tvalid && s_tready) begin
                c = s_tdata[43:20];
                premul_q.push_back(shade_pixel(s_tdata[9:0], s_tdata[19:10], c));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (premul_q.size() == 0) begin
                    flag_mismatch("word with nothing expected", 0, got);
                end else begin
                    want = premul_q.pop_front();
                    if (got.blue != want.blue)
                        flag_mismatch("out_blue", want.blue, got.blue);
                    if (got.green != want.green)
                        flag_mismatch("out_green", want.green, got.green);
                    if (got.red != want.red)
                        flag_mismatch("out_red", want.red, got.red);
                    if (got.alpha != want.alpha)
                        flag_mismatch("out_alpha", want.alpha, got.alpha);
                end
            end
        end
        outstanding = premul_q.size();
    end

endmodule

FILE: sim/tb_radial_alpha_brush_mask.sv
// ----------------------------------------------------------------------------
// Radial alpha brush mask testbench
// Directed pixels at the centre, rim and far corners, zero-radius and
// saturated brush sizes and unmapped register writes, then random pixels
// over many brush sizes with random gaps and back-pressure. The checker
// beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_radial_alpha_brush_mask;
    timeunit 1ns;
    timeprecision 1ps;

    import rabm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int DRAIN_CYCLES = 40;       // pipe is 22 deep
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 71;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [DIM_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;   // col, row, in_blue, in_green, in_red
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;          // out_blue, out_green, out_red, out_alpha
    int                   mismatches;
    int                   outstanding;
    bit                   calm = 1'b0;      // no gaps or stalls near the end
    int unsigned          cur_w = 64;
    int unsigned          cur_h = 64;

    always #6 aclk = ~aclk;

    radial_alpha_brush_mask DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    brush_mask_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // send one pixel, sometimes after a gap
    task automatic send_pixel(input int unsigned col, input int unsigned row,
                              input int unsigned b, input int unsigned g,
                              input int unsigned r);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r[7:0], g[7:0], b[7:0], row[9:0], col[9:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    // let the pipe empty before touching config
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[DIM_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_BRUSH_WIDTH)
            cur_w = val;
        else if (idx == REG_BRUSH_HEIGHT)
            cur_h = val;
    endtask

    // brush dimension: mostly modest, some degenerate and oversize
    function automatic int unsigned pick_dim();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(1025, 2047);
            1:       return $urandom_range(0, 3);
            2:       return 1024;
            3:       return $urandom_range(100, 1023);
            default: return $urandom_range(2, 96);
        endcase
    endfunction

    // random pixel, mostly inside the brush, some near centre, some anywhere
    task automatic send_random_pixel();
        int unsigned ew, eh, col, row, b, g, r;
        ew = (cur_w > 1024) ? 1024 : ((cur_w == 0) ? 1 : cur_w);
        eh = (cur_h > 1024) ? 1024 : ((cur_h == 0) ? 1 : cur_h);
        case ($urandom_range(0, 9))
            0, 1: begin
                col = $urandom_range(0, 1023);
                row = $urandom_range(0, 1023);
            end
            2: begin
                col = (ew / 2 + $urandom_range(0, 2) > 1023) ? 1023
                                                              : ew / 2 + $urandom_range(0, 2);
                row = (eh / 2 + $urandom_range(0, 2) > 1023) ? 1023
                                                              : eh / 2 + $urandom_range(0, 2);
            end
            default: begin
                col = $urandom_range(0, ew - 1);
                row = $urandom_range(0, eh - 1);
            end
        endcase
        b = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 255);
        g = ($urandom_range(0, 7) == 0) ? 0   : $urandom_range(0, 255);
        r = $urandom_range(0, 255);
        send_pixel(col, row, b, g, r);
    endtask

    // result side back-pressure
    initial begin : sink
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // hard stop
    initial begin : watchdog
        #5_000_000;
        $display("[radial_alpha_brush_mask] ERROR");
        $finish;
    end

    initial begin : stim
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size 64x64: centre, rim, just inside, far corners
        send_pixel(32, 32, 255, 255, 255);
        send_pixel(32, 32, 0, 0, 0);
        send_pixel(32, 0, 255, 255, 255);
        send_pixel(32, 1, 255, 128, 1);
        send_pixel(33, 32, 8'hAA, 8'h55, 8'h0F);
        send_pixel(0, 0, 255, 255, 255);
        send_pixel(1023, 1023, 255, 255, 255);
        send_pixel(1023, 0, 1, 2, 3);
        send_pixel(0, 1023, 200, 100, 50);
        drain();

        // unmapped indexes leave the brush alone
        write_reg(REG_SPARE_A, 11'h7FF);
        write_reg(REG_SPARE_B, 3);
        send_pixel(32, 32, 255, 255, 255);
        send_pixel(40, 20, 255, 255, 255);
        drain();

        // zero radius from empty and one-pixel brushes
        write_reg(REG_BRUSH_WIDTH, 0);
        write_reg(REG_BRUSH_HEIGHT, 0);
        send_pixel(0, 0, 255, 255, 255);
        drain();
        write_reg(REG_BRUSH_WIDTH, 1);
        write_reg(REG_BRUSH_HEIGHT, 1);
        send_pixel(0, 0, 255, 255, 255);
        send_pixel(1, 1, 255, 255, 255);
        drain();

        // oversize width saturates to the largest brush
        write_reg(REG_BRUSH_WIDTH, 2047);
        write_reg(REG_BRUSH_HEIGHT, 0);
        send_pixel(512, 0, 255, 255, 255);
        send_pixel(512, 512, 255, 255, 255);
        send_pixel(1023, 1023, 255, 255, 255);
        drain();

        // random phases across brush sizes, last one without idling
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_BRUSH_WIDTH, 1024);
                    write_reg(REG_BRUSH_HEIGHT, 1024);
                end
                1: begin
                    write_reg(REG_BRUSH_WIDTH, 2);
                    write_reg(REG_BRUSH_HEIGHT, 1);
                end
                2: begin
                    write_reg(REG_BRUSH_WIDTH, 7);
                    write_reg(REG_BRUSH_HEIGHT, 300);
                end
                default: begin
                    write_reg(REG_BRUSH_WIDTH, pick_dim());
                    write_reg(REG_BRUSH_HEIGHT, pick_dim());
                end
            endcase
            if (ph == RAND_PHASES - 1)
                calm = 1'b1;
            repeat (PHASE_ITEMS) send_random_pixel();
            drain();
        end

        if (mismatches == 0)
            $display("[radial_alpha_brush_mask] OK");
        else
            $display("[radial_alpha_brush_mask] ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/rabm_pkg.sv
rtl/rabm_dist.sv
rtl/rabm_isqrt.sv
rtl/rabm_scale.sv
rtl/radial_alpha_brush_mask.sv
sim/brush_mask_checker.sv
sim/tb_radial_alpha_brush_mask.sv
